FILE: sv/tmhe_pkg.sv
// tmhe_pkg: shared types and constants of the timer min-heap engine
// no dependencies; imported by the core and the checker (tmhe_ram does not use it)
`default_nettype none
package tmhe_pkg;

   localparam int HeapDepthDefault = 64;
   localparam int NumTimers        = 64;
   localparam int MaxResults       = 64;
   localparam int ExpW             = 48;
   localparam int IdW              = 6;
   localparam int IvlW             = 32;

   // operation codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_IDLE    = 2'd3;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      logic [1:0]      op;
      logic [IdW-1:0]  timer_id;
      logic [IvlW-1:0] delay_ms;
      logic            periodic;
   } req_type;

   typedef struct packed {
      logic            result_kind;
      logic [IdW-1:0]  expired_id;
      logic [1:0]      status;
      logic            last;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [ExpW-1:0] expiry;
      logic [IdW-1:0]  tid;
   } slot_type;

   // per-timer settings
   typedef struct packed {
      logic [IvlW-1:0] interval;
      logic            repeat_en;
   } tmr_type;

endpackage
`default_nettype wire

FILE: sv/tmhe_ram.sv
// tmhe_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
`default_nettype none
module tmhe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/timer_min_heap_engine_core.sv
// timer_min_heap_engine_core: software-timer queue as a binary min-heap in ram
// depends on tmhe_pkg and tmhe_ram
//
//  channel  | ports                  | handshake
//  request  | start, busy, req_data  | taken when start high and busy low
//  response | rsp_valid, rsp_data    | one-cycle strobe, cannot be held off
//
// start: refused ones answer the cycle after acceptance without going busy;
//   else a sift-up per parent level, then S_WR writes; result the cycle after.
// stop: a linear heap search, S_RM_RD and S_RM_D fetch the last slot, then
//   a sift-down reading both children per level (or sift-up); S_WR writes.
// tick: a heap-top check (S_CHK, S_CHK_D), plus a pop sift-down per expired timer
//   and a re-arm sift-up per periodic one; up to 64 expiry results per tick.
// synchronous reset clears count, time and active flags; no clearing pass.
// results leave as one-cycle strobes, the receiver never stalls the block.
`default_nettype none
module timer_min_heap_engine_core #(
   parameter int HEAP_DEPTH = tmhe_pkg::HeapDepthDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tmhe_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tmhe_pkg::rsp_type     rsp_data
);
   import tmhe_pkg::*;

   localparam int AW  = $clog2(HEAP_DEPTH);
   localparam int CW  = $clog2(HEAP_DEPTH + 1);
   localparam int IW  = AW + 2;
   localparam int TAW = $clog2(NumTimers);
   localparam int NW  = $clog2(MaxResults + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_RM_RD, S_RM_D, S_DN_RL, S_DN_RR, S_DN_CMP,
      S_UP_RD, S_UP_CMP, S_WR, S_CHK, S_CHK_D, S_POP_D
   } state_type;

   typedef enum logic [1:0] {
      CTX_START, CTX_STOP, CTX_POP, CTX_PUSH
   } ctx_type;

   state_type            state_ff, state_in;
   ctx_type              ctx_ff, ctx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [ExpW-1:0]      now_ff, now_in;
   logic [NumTimers-1:0] active_ff, active_in;
   slot_type             mov_ff, mov_in;
   slot_type             lval_ff, lval_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic                 r_ok_ff, r_ok_in;
   logic                 moved_ff, moved_in;
   logic                 up_after_ff, up_after_in;
   logic [IdW-1:0]       id_ff, id_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 pend_ff, pend_in;
   logic [IdW-1:0]       pend_id_ff, pend_id_in;
   logic [NW-1:0]        n_ff, n_in;
   logic                 rep_ff, rep_in;
   logic [IvlW-1:0]      ivl_ff, ivl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // ram ports
   logic                 heap_we;
   logic [AW-1:0]        heap_waddr, heap_raddr;
   slot_type             heap_wdata, heap_rdata;
   logic [$bits(slot_type)-1:0] heap_rd_raw;
   logic                 tmr_we;
   logic [TAW-1:0]       tmr_waddr, tmr_raddr;
   tmr_type              tmr_wdata, tmr_rdata;
   logic [$bits(tmr_type)-1:0] tmr_rd_raw;

   // heap slot store
   tmhe_ram #(.WIDTH($bits(slot_type)), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rd_raw)
   );
   assign heap_rdata = slot_type'(heap_rd_raw);

   // per-timer interval and repeat store
   tmhe_ram #(.WIDTH($bits(tmr_type)), .DEPTH(NumTimers)) u_tmr (
      .clock   (clock),
      .wr_en   (tmr_we),
      .wr_addr (tmr_waddr),
      .wr_data (tmr_wdata),
      .rd_addr (tmr_raddr),
      .rd_data (tmr_rd_raw)
   );
   assign tmr_rdata = tmr_type'(tmr_rd_raw);

   // heap index arithmetic
   logic [IW-1:0]   idx_l, idx_r, cnt_x;
   logic [AW-1:0]   parent;
   logic [CW-1:0]   cnt_m1;
   logic [IvlW-1:0] ivl_fix;
   slot_type        pick_val;
   logic [AW-1:0]   pick_idx;
   logic            accept;

   assign idx_l   = {1'b0, pos_ff, 1'b1};
   assign idx_r   = {1'b0, pos_ff, 1'b0} + IW'(2);
   assign cnt_x   = IW'(count_ff);
   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign cnt_m1  = count_ff - CW'(1);
   assign ivl_fix = (req_data.delay_ms == '0) ? IvlW'(1) : req_data.delay_ms;
   assign accept  = start && !busy;

   // right child only when strictly smaller
   always_comb begin
      if (r_ok_ff && (heap_rdata.expiry < lval_ff.expiry)) begin
         pick_val = heap_rdata;
         pick_idx = idx_r[AW-1:0];
      end else begin
         pick_val = lval_ff;
         pick_idx = idx_l[AW-1:0];
      end
   end

   // control and datapath
   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      active_in    = active_ff;
      mov_in       = mov_ff;
      lval_in      = lval_ff;
      pos_in       = pos_ff;
      r_ok_in      = r_ok_ff;
      moved_in     = moved_ff;
      up_after_in  = up_after_ff;
      id_in        = id_ff;
      scan_in      = scan_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      n_in         = n_ff;
      rep_in       = rep_ff;
      ivl_in       = ivl_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      heap_we      = 1'b0;
      heap_waddr   = pos_ff;
      heap_wdata   = mov_ff;
      heap_raddr   = '0;
      tmr_we       = 1'b0;
      tmr_waddr    = req_data.timer_id;
      tmr_wdata    = '{interval: ivl_fix, repeat_en: req_data.periodic};
      tmr_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in = req_data.timer_id;
               case (req_data.op)
                  OP_START: begin
                     if (active_ff[req_data.timer_id]) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{KIND_STATUS, req_data.timer_id, ST_RUNNING, 1'b1};
                     end else if (count_ff >= CW'(HEAP_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{KIND_STATUS, req_data.timer_id, ST_FULL, 1'b1};
                     end else begin
                        tmr_we = 1'b1;
                        active_in[req_data.timer_id] = 1'b1;
                        mov_in = '{expiry: now_ff + ExpW'(ivl_fix),
                                   tid: req_data.timer_id};
                        pos_in   = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                        ctx_in   = CTX_START;
                        state_in = (count_ff == '0) ? S_WR : S_UP_RD;
                     end
                  end
                  OP_STOP: begin
                     if (!active_ff[req_data.timer_id]) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{KIND_STATUS, req_data.timer_id, ST_IDLE, 1'b1};
                     end else begin
                        scan_in    = '0;
                        chk_vld_in = 1'b0;
                        state_in   = S_SRCH;
                     end
                  end
                  OP_TICK: begin
                     now_in   = now_ff + ExpW'(1);
                     n_in     = '0;
                     pend_in  = 1'b0;
                     state_in = S_CHK;
                  end
                  default: ;
               endcase
            end
         end

         // pipelined linear search, one slot per cycle
         S_SRCH: begin
            heap_raddr = scan_ff[AW-1:0];
            if (chk_vld_ff && (heap_rdata.tid == id_ff)) begin
               pos_in   = chk_idx_ff;
               state_in = S_RM_RD;
            end else if (scan_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{KIND_STATUS, id_ff, ST_IDLE, 1'b1};
               state_in = S_IDLE;
            end
         end

         // fetch last slot to fill the hole
         S_RM_RD: begin
            heap_raddr = cnt_m1[AW-1:0];
            count_in   = cnt_m1;
            active_in[id_ff] = 1'b0;
            state_in   = S_RM_D;
         end

         S_RM_D: begin
            if (CW'(pos_ff) == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{KIND_STATUS, id_ff, ST_OK, 1'b1};
               state_in = S_IDLE;
            end else begin
               mov_in      = heap_rdata;
               moved_in    = 1'b0;
               up_after_in = 1'b1;
               ctx_in      = CTX_STOP;
               state_in    = S_DN_RL;
            end
         end

         // sift-down: read left child
         S_DN_RL: begin
            heap_raddr = idx_l[AW-1:0];
            if (idx_l >= cnt_x) begin
               if (!up_after_ff || moved_ff || (pos_ff == '0)) begin
                  state_in = S_WR;
               end else begin
                  state_in = S_UP_RD;
               end
            end else begin
               state_in = S_DN_RR;
            end
         end

         // sift-down: read right child, capture left
         S_DN_RR: begin
            heap_raddr = idx_r[AW-1:0];
            lval_in    = heap_rdata;
            r_ok_in    = idx_r < cnt_x;
            state_in   = S_DN_CMP;
         end

         S_DN_CMP: begin
            if (mov_ff.expiry <= pick_val.expiry) begin
               if (!up_after_ff || moved_ff || (pos_ff == '0)) begin
                  state_in = S_WR;
               end else begin
                  state_in = S_UP_RD;
               end
            end else begin
               heap_we    = 1'b1;
               heap_wdata = pick_val;
               pos_in     = pick_idx;
               moved_in   = 1'b1;
               state_in   = S_DN_RL;
            end
         end

         // sift-up: read parent
         S_UP_RD: begin
            heap_raddr = parent;
            state_in   = S_UP_CMP;
         end

         S_UP_CMP: begin
            if (mov_ff.expiry < heap_rdata.expiry) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               pos_in     = parent;
               state_in   = (parent == '0) ? S_WR : S_UP_RD;
            end else begin
               state_in = S_WR;
            end
         end

         // place the carried slot
         S_WR: begin
            heap_we = 1'b1;
            case (ctx_ff)
               CTX_START, CTX_STOP: begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{KIND_STATUS, id_ff, ST_OK, 1'b1};
                  state_in = S_IDLE;
               end
               CTX_POP: begin
                  if (rep_ff) begin
                     mov_in   = '{expiry: now_ff + ExpW'(ivl_ff), tid: pend_id_ff};
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     ctx_in   = CTX_PUSH;
                     state_in = (count_ff == '0) ? S_WR : S_UP_RD;
                  end else begin
                     state_in = S_CHK;
                  end
               end
               default: state_in = S_CHK;
            endcase
         end

         // tick: look at the heap top
         S_CHK: begin
            heap_raddr = '0;
            if (count_ff == '0) begin
               rsp_valid_in = pend_ff;
               rsp_in = '{KIND_EXPIRY, pend_id_ff, ST_OK, 1'b1};
               state_in = S_IDLE;
            end else begin
               state_in = S_CHK_D;
            end
         end

         // tick: test the heap top for expiry, fetch last slot and the timer settings
         S_CHK_D: begin
            heap_raddr = cnt_m1[AW-1:0];
            tmr_raddr  = heap_rdata.tid;
            if ((now_ff >= heap_rdata.expiry) && (n_ff < NW'(MaxResults))) begin
               rsp_valid_in = pend_ff;
               rsp_in = '{KIND_EXPIRY, pend_id_ff, ST_OK, 1'b0};
               pend_in    = 1'b1;
               pend_id_in = heap_rdata.tid;
               n_in       = n_ff + NW'(1);
               count_in   = cnt_m1;
               state_in   = S_POP_D;
            end else begin
               rsp_valid_in = pend_ff;
               rsp_in = '{KIND_EXPIRY, pend_id_ff, ST_OK, 1'b1};
               state_in = S_IDLE;
            end
         end

         // last slot goes to the top, timer re-armed only if periodic
         S_POP_D: begin
            active_in[pend_id_ff] = tmr_rdata.repeat_en;
            rep_in      = tmr_rdata.repeat_en;
            ivl_in      = tmr_rdata.interval;
            mov_in      = heap_rdata;
            pos_in      = '0;
            moved_in    = 1'b0;
            up_after_in = 1'b0;
            ctx_in      = CTX_POP;
            state_in    = S_DN_RL;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
         chk_vld_ff   <= chk_vld_in;
      end
      ctx_ff      <= ctx_in;
      mov_ff      <= mov_in;
      lval_ff     <= lval_in;
      pos_ff      <= pos_in;
      r_ok_ff     <= r_ok_in;
      moved_ff    <= moved_in;
      up_after_ff <= up_after_in;
      id_ff       <= id_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      pend_id_ff  <= pend_id_in;
      rsp_ff      <= rsp_in;
      rep_ff      <= rep_in;
      ivl_ff      <= ivl_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/tmhe_checker.sv
// tmhe_checker: port-level assertions for timer_min_heap_engine_core
// depends on tmhe_pkg; bound to the top level at the end of this file
`default_nettype none
module tmhe_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire tmhe_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire tmhe_pkg::rsp_type rsp_data
);
   import tmhe_pkg::*;

   // a status transaction is always the only result of its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_STATUS) |-> rsp_data.last)
      else $error("status result without last");

   // expiry results carry status ok
   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_EXPIRY) |-> rsp_data.status == ST_OK)
      else $error("expiry result with nonzero status");

   // more results of a tick follow while the engine stays busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-final result while idle");

   // an accepted start either answers at once or keeps working
   a_start_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_START) |=> rsp_valid || busy)
      else $error("start transaction dropped");

endmodule

bind timer_min_heap_engine_core tmhe_checker u_tmhe_checker (.*);
`default_nettype wire
